/* rtl/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg
// shared types, address map constants and store sizes of the bus decoder
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int WORK_RAM_BYTES = 2048;
  localparam int SAVE_RAM_BYTES = 8192;
  localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
  localparam int SRAM_AW        = $clog2(SAVE_RAM_BYTES);

  // address map
  localparam logic [15:0] ADDR_WRAM_MASK = 16'h07FF;
  localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
  localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
  localparam logic [15:0] ADDR_DMA       = 16'h4014;
  localparam logic [15:0] ADDR_SND_STAT  = 16'h4015;
  localparam logic [15:0] ADDR_JOY1      = 16'h4016;
  localparam logic [15:0] ADDR_JOY2      = 16'h4017;
  localparam logic [15:0] ADDR_IO_END    = 16'h4020;
  localparam logic [15:0] ADDR_SRAM_BASE = 16'h6000;
  localparam logic [15:0] ADDR_CART_BASE = 16'h8000;
  localparam logic [7:0]  OPEN_BUS_DATA  = 8'hFF;

  typedef enum logic [2:0] {
    TGT_WRAM  = 3'd0,
    TGT_PPU   = 3'd1,
    TGT_SOUND = 3'd2,
    TGT_JOY   = 3'd3,
    TGT_OPEN  = 3'd4,
    TGT_SRAM  = 3'd5,
    TGT_CART  = 3'd6,
    TGT_DMA   = 3'd7
  } target_e;

  typedef enum logic [1:0] {
    JOY_NONE   = 2'd0,
    JOY_STROBE = 2'd1,
    JOY_READ   = 2'd2
  } joy_op_e;

  typedef struct packed {
    joy_op_e op;
    logic    strobe_val;
  } joy_ctrl_t;

  typedef struct packed {
    target_e     target;
    logic [15:0] offset;
    logic [7:0]  data;
    logic        data_valid;
    logic        wram_we;
    logic        wram_re;
    logic        sram_we;
    logic        sram_re;
  } dec_t;

endpackage

/* rtl/cbd_ram.sv */
// ----------------------------------------------------------------------------
// cbd_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cbd_joypad.sv */
// ----------------------------------------------------------------------------
// cbd_joypad
// two serial pad shift registers with a common strobe
// ----------------------------------------------------------------------------
module cbd_joypad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cbd_pkg::joy_ctrl_t ctrl_i,
  input  logic              port_i,
  input  logic [7:0]        pad1_buttons_i,
  input  logic [7:0]        pad2_buttons_i,
  output logic              bit_o
);
  import cbd_pkg::*;

  logic [7:0] shift_q [2];
  logic [7:0] shift_d [2];
  logic       strobe_q, strobe_d;
  logic [7:0] live_sel;

  assign live_sel = port_i ? pad2_buttons_i : pad1_buttons_i;
  assign bit_o    = strobe_q ? live_sel[7] : shift_q[port_i][7];

  always_comb begin
    shift_d  = shift_q;
    strobe_d = strobe_q;
    if (accept_i) begin
      unique case (ctrl_i.op)
        JOY_STROBE: begin
          // falling edge, rising edge or strobe held high reloads both pads
          if (strobe_q || ctrl_i.strobe_val) begin
            shift_d[0] = pad1_buttons_i;
            shift_d[1] = pad2_buttons_i;
          end
          strobe_d = ctrl_i.strobe_val;
        end
        JOY_READ: begin
          if (strobe_q) begin
            shift_d[0] = pad1_buttons_i;
            shift_d[1] = pad2_buttons_i;
          end else begin
            shift_d[port_i] = {shift_q[port_i][6:0], 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      strobe_q   <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      strobe_q <= strobe_d;
    end
  end

endmodule

/* rtl/cbd_decode.sv */
// ----------------------------------------------------------------------------
// cbd_decode
// address map decode of one bus request
// ----------------------------------------------------------------------------
module cbd_decode (
  input  logic              op_i,
  input  logic [15:0]       addr_i,
  input  logic [7:0]        wdata_i,
  input  logic              joy_bit_i,
  output cbd_pkg::dec_t     dec_o,
  output cbd_pkg::joy_ctrl_t joy_o
);
  import cbd_pkg::*;

  always_comb begin
    dec_o            = '0;
    dec_o.target     = TGT_OPEN;
    dec_o.offset     = addr_i;
    joy_o.op         = JOY_NONE;
    joy_o.strobe_val = wdata_i[0];
    if (addr_i < ADDR_PPU_BASE) begin
      dec_o.target     = TGT_WRAM;
      dec_o.offset     = addr_i & ADDR_WRAM_MASK;
      dec_o.data       = wdata_i;
      dec_o.data_valid = !op_i;
      dec_o.wram_we    = op_i;
      dec_o.wram_re    = !op_i;
    end else if (addr_i < ADDR_IO_BASE) begin
      dec_o.target = TGT_PPU;
      dec_o.offset = {13'd0, addr_i[2:0]};
      dec_o.data   = op_i ? wdata_i : 8'd0;
    end else if (addr_i >= ADDR_CART_BASE) begin
      dec_o.target = TGT_CART;
      dec_o.data   = op_i ? wdata_i : 8'd0;
    end else if (addr_i >= ADDR_SRAM_BASE) begin
      dec_o.target     = TGT_SRAM;
      dec_o.offset     = addr_i - ADDR_SRAM_BASE;
      dec_o.data       = wdata_i;
      dec_o.data_valid = !op_i;
      dec_o.sram_we    = op_i;
      dec_o.sram_re    = !op_i;
    end else if (op_i) begin
      dec_o.data = wdata_i;
      priority if (addr_i == ADDR_DMA) begin
        dec_o.target = TGT_DMA;
      end else if (addr_i == ADDR_JOY1) begin
        dec_o.target = TGT_JOY;
        dec_o.offset = 16'd0;
        joy_o.op     = JOY_STROBE;
      end else if (addr_i <= ADDR_JOY2) begin
        dec_o.target = TGT_SOUND;
      end else begin
        dec_o.target = TGT_OPEN;
      end
    end else begin
      priority if (addr_i == ADDR_SND_STAT) begin
        dec_o.target = TGT_SOUND;
      end else if (addr_i == ADDR_JOY1 || addr_i == ADDR_JOY2) begin
        dec_o.target     = TGT_JOY;
        dec_o.offset     = {15'd0, addr_i[0]};
        dec_o.data       = {7'd0, joy_bit_i};
        dec_o.data_valid = 1'b1;
        joy_o.op         = JOY_READ;
      end else begin
        // rest of the i/o page and the unmapped window read as open bus
        dec_o.target     = TGT_OPEN;
        dec_o.data       = OPEN_BUS_DATA;
        dec_o.data_valid = 1'b1;
      end
    end
  end

endmodule

/* rtl/cpu_bus_decoder_with_joypad_unit.sv */
// ----------------------------------------------------------------------------
// cpu_bus_decoder_with_joypad_unit
// cpu bus address decoder with work ram, save ram and two serial joypads
// ----------------------------------------------------------------------------
// Takes one bus request per clock and returns one result per request, in the
// cycle after acceptance, in order. Work ram (2 KB, mirrored below 0x2000)
// and save ram (8 KB at 0x6000) are single-port rams with registered read
// data; the ram read and the joypad update happen at the accepting edge and
// the result sits in one output register. Sustained rate is one request per
// cycle when nothing stalls. While a result is held by out_stall_i the
// next request waits. After reset a clearing pass zeroes both rams, one
// address per cycle, running once over the save ram depth; no request is
// accepted until it has finished.
module cpu_bus_decoder_with_joypad_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [15:0]            addr_i,
  input  logic [7:0]             wdata_i,
  input  logic [7:0]             pad1_buttons_i,
  input  logic [7:0]             pad2_buttons_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cbd_pkg::target_e       target_o,
  output logic [15:0]            offset_o,
  output logic [7:0]             data_o,
  output logic                   data_valid_o
);
  import cbd_pkg::*;

  // clearing pass after reset
  logic               clear_busy_q, clear_busy_d;
  logic [SRAM_AW-1:0] clear_cnt_q, clear_cnt_d;

  logic      accept;
  dec_t      dec;
  joy_ctrl_t joy_ctrl;
  logic      joy_bit;

  // ram ports
  logic               wram_we, wram_re;
  logic [WRAM_AW-1:0] wram_addr;
  logic [7:0]         wram_wdata, wram_rdata;
  logic               sram_we, sram_re;
  logic [SRAM_AW-1:0] sram_addr;
  logic [7:0]         sram_wdata, sram_rdata;

  // output register
  logic        out_valid_q, out_valid_d;
  target_e     target_q;
  logic [15:0] offset_q;
  logic [7:0]  data_q;
  logic        data_valid_q;

  // a held result blocks the next request; so does the clearing pass
  assign in_stall_o = clear_busy_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  cbd_decode u_decode (
    .op_i      (op_i),
    .addr_i    (addr_i),
    .wdata_i   (wdata_i),
    .joy_bit_i (joy_bit),
    .dec_o     (dec),
    .joy_o     (joy_ctrl)
  );

  cbd_joypad u_joypad (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .ctrl_i         (joy_ctrl),
    .port_i         (addr_i[0]),
    .pad1_buttons_i (pad1_buttons_i),
    .pad2_buttons_i (pad2_buttons_i),
    .bit_o          (joy_bit)
  );

  // ram port muxing: clearing pass owns the write port until done
  assign wram_we    = clear_busy_q || (accept && dec.wram_we);
  assign wram_re    = accept && dec.wram_re;
  assign wram_addr  = clear_busy_q ? clear_cnt_q[WRAM_AW-1:0] : dec.offset[WRAM_AW-1:0];
  assign wram_wdata = clear_busy_q ? 8'd0 : wdata_i;

  assign sram_we    = clear_busy_q || (accept && dec.sram_we);
  assign sram_re    = accept && dec.sram_re;
  assign sram_addr  = clear_busy_q ? clear_cnt_q : dec.offset[SRAM_AW-1:0];
  assign sram_wdata = clear_busy_q ? 8'd0 : wdata_i;

  cbd_ram #(
    .DEPTH (WORK_RAM_BYTES),
    .WIDTH (8)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .re_i    (wram_re),
    .addr_i  (wram_addr),
    .wdata_i (wram_wdata),
    .rdata_o (wram_rdata)
  );

  cbd_ram #(
    .DEPTH (SAVE_RAM_BYTES),
    .WIDTH (8)
  ) u_save_ram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .re_i    (sram_re),
    .addr_i  (sram_addr),
    .wdata_i (sram_wdata),
    .rdata_o (sram_rdata)
  );

  // clearing counter runs once over the save ram depth
  always_comb begin
    clear_busy_d = clear_busy_q;
    clear_cnt_d  = clear_cnt_q;
    if (clear_busy_q) begin
      clear_cnt_d = clear_cnt_q + 1'b1;
      if (clear_cnt_q == SRAM_AW'(SAVE_RAM_BYTES - 1)) begin
        clear_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_busy_q <= 1'b1;
      clear_cnt_q  <= '0;
    end else begin
      clear_busy_q <= clear_busy_d;
      clear_cnt_q  <= clear_cnt_d;
    end
  end

  // result register: holds under stall, reloads on every accepted request
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q     <= dec.target;
      offset_q     <= dec.offset;
      data_q       <= dec.data;
      data_valid_q <= dec.data_valid;
    end
  end

  // ram read data lands in the ram's own register, picked here by target
  always_comb begin
    data_o = data_q;
    if (data_valid_q && target_q == TGT_WRAM) begin
      data_o = wram_rdata;
    end else if (data_valid_q && target_q == TGT_SRAM) begin
      data_o = sram_rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign target_o     = target_q;
  assign offset_o     = offset_q;
  assign data_valid_o = data_valid_q;

endmodule

/* tb/bus_result_checker.sv */
// ----------------------------------------------------------------------------
// bus_result_checker
// watches both channels of the bus decoder, predicts each result and compares
// ----------------------------------------------------------------------------
module bus_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  logic              op_i,
  input  logic [15:0]       addr_i,
  input  logic [7:0]        wdata_i,
  input  logic [7:0]        pad1_buttons_i,
  input  logic [7:0]        pad2_buttons_i,
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  cbd_pkg::target_e  target_i,
  input  logic [15:0]       offset_i,
  input  logic [7:0]        data_i,
  input  logic              data_valid_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  typedef struct packed {
    target_e     target;
    logic [15:0] offset;
    logic [7:0]  data;
    logic        data_valid;
  } bus_result_t;

  // own copy of the block state
  logic [7:0] wram_model [WORK_RAM_BYTES];
  logic [7:0] sram_model [SAVE_RAM_BYTES];
  logic [7:0] pad_shift [2];
  logic       strobe;

  bus_result_t bus_results_q [$];
  int          fails   = 0;
  int          checked = 0;

  function automatic bus_result_t decode_bus_access(input logic wr, input logic [15:0] a,
                                                    input logic [7:0] wd,
                                                    input logic [7:0] live1,
                                                    input logic [7:0] live2);
    bus_result_t       r;
    logic [WRAM_AW-1:0] wo;
    logic [15:0]       sdiff;
    logic [SRAM_AW-1:0] so;
    logic [7:0]        live [2];
    logic              ns;
    logic              p;
    live[0] = live1;
    live[1] = live2;
    // default is an open bus read
    r = '{target: TGT_OPEN, offset: a, data: OPEN_BUS_DATA, data_valid: 1'b1};
    if (a < ADDR_PPU_BASE) begin
      wo       = a[WRAM_AW-1:0];
      r.target = TGT_WRAM;
      r.offset = 16'(wo);
      if (wr) begin
        wram_model[wo] = wd;
        r.data         = wd;
        r.data_valid   = 1'b0;
      end else begin
        r.data = wram_model[wo];
      end
    end else if (a < ADDR_IO_BASE) begin
      r = '{target: TGT_PPU, offset: {13'd0, a[2:0]}, data: wr ? wd : 8'h00,
            data_valid: 1'b0};
    end else if (a >= ADDR_SRAM_BASE && a < ADDR_CART_BASE) begin
      sdiff    = a - ADDR_SRAM_BASE;
      so       = sdiff[SRAM_AW-1:0];
      r.target = TGT_SRAM;
      r.offset = 16'(so);
      if (wr) begin
        sram_model[so] = wd;
        r.data         = wd;
        r.data_valid   = 1'b0;
      end else begin
        r.data = sram_model[so];
      end
    end else if (a >= ADDR_CART_BASE) begin
      r = '{target: TGT_CART, offset: a, data: wr ? wd : 8'h00, data_valid: 1'b0};
    end else if (wr) begin
      r.data       = wd;
      r.data_valid = 1'b0;
      if (a == ADDR_DMA) begin
        r.target = TGT_DMA;
      end else if (a == ADDR_JOY1) begin
        // strobe write, reload on falling edge or while old or new strobe is high
        ns = wd[0];
        if (strobe || ns) begin
          pad_shift[0] = live[0];
          pad_shift[1] = live[1];
        end
        strobe   = ns;
        r.target = TGT_JOY;
        r.offset = 16'd0;
      end else if (a <= ADDR_JOY2) begin
        r.target = TGT_SOUND;
      end
    end else if (a == ADDR_SND_STAT) begin
      r = '{target: TGT_SOUND, offset: a, data: 8'h00, data_valid: 1'b0};
    end else if (a == ADDR_JOY1 || a == ADDR_JOY2) begin
      p        = a[0];
      r.target = TGT_JOY;
      r.offset = {15'd0, p};
      if (strobe) begin
        pad_shift[0] = live[0];
        pad_shift[1] = live[1];
        r.data       = {7'd0, live[p][7]};
      end else begin
        r.data       = {7'd0, pad_shift[p][7]};
        pad_shift[p] = {pad_shift[p][6:0], 1'b1};
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_ni) begin
      wram_model = '{default: 8'h00};
      sram_model = '{default: 8'h00};
      pad_shift  = '{default: 8'h00};
      strobe     = 1'b0;
      bus_results_q.delete();
    end else begin
      // result side first: a result never belongs to a request of this edge
      if (res_valid_i && !res_stall_i) begin
        got = '{target: target_i, offset: offset_i, data: data_i, data_valid: data_valid_i};
        checked++;
        if (bus_results_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none,", $time,
                   " got target %0d offset %h data %h valid %b",
                   got.target, got.offset, got.data, got.data_valid);
        end else begin
          want = bus_results_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch, expected target %0d offset %h data %h valid %b,",
                     $time, want.target, want.offset, want.data, want.data_valid,
                     " got target %0d offset %h data %h valid %b",
                     got.target, got.offset, got.data, got.data_valid);
          end
        end
      end
      if (req_valid_i && !req_stall_i)
        bus_results_q.push_back(decode_bus_access(op_i, addr_i, wdata_i,
                                                  pad1_buttons_i, pad2_buttons_i));
    end
    fail_count_o <= fails;
    pending_o    <= bus_results_q.size();
    checked_o    <= checked;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives bus requests into the decoder and gives the verdict of the checker
// ----------------------------------------------------------------------------
// A short directed list covers every window of the address map, the edges of
// the stores and the joypad strobe cases. A random part then mixes RAM
// write/read-back bursts, strobe/shift sequences on both pads, I/O window
// accesses and raw noise, cycling through four idling phases on the request
// and result channels. The checker predicts and compares every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  localparam int RANDOM_REQUESTS = 1500;
  // longest quiet stretch allowed: covers the clearing pass
  // after reset with plenty of margin for stalls
  localparam int IDLE_LIMIT      = 40000;
  localparam int DRAIN_CYCLES    = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        req_op    = 1'b0;
  logic [15:0] req_addr  = 16'h0000;
  logic [7:0]  req_wdata = 8'h00;
  logic [7:0]  pad1      = 8'h00;
  logic [7:0]  pad2      = 8'h00;

  // result channel
  logic        res_valid;
  logic        res_stall = 1'b0;
  target_e     res_target;
  logic [15:0] res_offset;
  logic [7:0]  res_data;
  logic        res_data_valid;

  int fail_count;
  int pending;
  int checked;

  // idling percentages of the current phase
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent          = 0;

  always #5 clk_i = ~clk_i;

  cpu_bus_decoder_with_joypad_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_stall_o     (req_stall),
    .op_i           (req_op),
    .addr_i         (req_addr),
    .wdata_i        (req_wdata),
    .pad1_buttons_i (pad1),
    .pad2_buttons_i (pad2),
    .out_valid_o    (res_valid),
    .out_stall_i    (res_stall),
    .target_o       (res_target),
    .offset_o       (res_offset),
    .data_o         (res_data),
    .data_valid_o   (res_data_valid)
  );

  bus_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_stall_i    (req_stall),
    .op_i           (req_op),
    .addr_i         (req_addr),
    .wdata_i        (req_wdata),
    .pad1_buttons_i (pad1),
    .pad2_buttons_i (pad2),
    .res_valid_i    (res_valid),
    .res_stall_i    (res_stall),
    .target_i       (res_target),
    .offset_i       (res_offset),
    .data_i         (res_data),
    .data_valid_i   (res_data_valid),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // receiver back-pressure, one draw per cycle
  always @(posedge clk_i) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // one bus request: optional idle gap, then hold until accepted; the caller
  // is always at a rising edge, and valid is only raised or lowered once per edge
  task automatic issue(input logic wr, input logic [15:0] a, input logic [7:0] wd);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        req_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_valid <= 1'b1;
    req_op    <= wr;
    req_addr  <= a;
    req_wdata <= wd;
    // live buttons change on every request
    pad1      <= 8'($urandom);
    pad2      <= 8'($urandom);
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
    sent++;
  endtask

  // watchdog: ends the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid && !req_stall) || (res_valid && !res_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [10:0] wbase;
    logic [12:0] sbase;
    int          burst;
    int          kind;
    int          directed;

    // reset held low at the start, released once
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed part, no idling ----------------
    issue(1'b0, 16'h0000, 8'h00);            // read of cleared work ram
    issue(1'b1, 16'h0000, 8'hFF);
    issue(1'b1, 16'h1FFF, 8'hA5);            // top mirror, offset 0x7ff
    issue(1'b0, 16'h1800, 8'h00);            // mirror of 0x0000
    issue(1'b0, 16'h07FF, 8'h00);
    issue(1'b1, 16'h2000, 8'hFF);            // picture regs
    issue(1'b0, 16'h3FFF, 8'h00);
    issue(1'b0, 16'h4000, 8'h00);            // open bus inside io window
    issue(1'b1, 16'h4014, 8'h02);            // sprite dma request
    issue(1'b0, 16'h4014, 8'h00);            // dma register reads as open bus
    issue(1'b0, 16'h4015, 8'h00);            // sound status forwarded
    issue(1'b0, 16'h4016, 8'h00);            // shift out of cleared register
    issue(1'b1, 16'h4016, 8'h01);            // strobe high
    issue(1'b0, 16'h4016, 8'h00);            // read while strobe high
    issue(1'b0, 16'h4017, 8'h00);
    issue(1'b1, 16'h4016, 8'hFE);            // falling strobe, latch buttons
    issue(1'b0, 16'h4016, 8'h00);
    issue(1'b0, 16'h4017, 8'h00);
    issue(1'b1, 16'h4017, 8'hFF);            // goes to sound, not the pads
    issue(1'b1, 16'h401F, 8'h12);            // ignored write
    issue(1'b0, 16'h4020, 8'h00);            // unmapped read
    issue(1'b1, 16'h5FFF, 8'h77);            // unmapped write
    issue(1'b1, 16'h6000, 8'hFF);
    issue(1'b1, 16'h7FFF, 8'h3C);
    issue(1'b0, 16'h6000, 8'h00);
    issue(1'b0, 16'h7FFF, 8'h00);
    issue(1'b0, 16'h8000, 8'h00);            // cartridge
    issue(1'b1, 16'hFFFF, 8'hFF);
    directed = sent;

    // ---------------- random part ----------------
    while (sent < directed + RANDOM_REQUESTS) begin
      // rotate the idling phase every 150 requests
      case (((sent - directed) / 150) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      kind = $urandom_range(99);
      if (kind < 30) begin
        // work ram burst, read back through random mirrors
        wbase = 11'($urandom);
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++)
          issue(1'b1, {3'b000, 2'($urandom), 11'(wbase + k)}, 8'($urandom));
        for (int k = 0; k < burst; k++)
          issue(1'b0, {3'b000, 2'($urandom), 11'(wbase + k)}, 8'($urandom));
      end else if (kind < 45) begin
        // save ram burst
        sbase = 13'($urandom);
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++)
          issue(1'b1, {3'b011, 13'(sbase + k)}, 8'($urandom));
        for (int k = 0; k < burst; k++)
          issue(1'b0, {3'b011, 13'(sbase + k)}, 8'($urandom));
      end else if (kind < 65) begin
        // strobe then shift, sometimes without the falling write
        issue(1'b1, ADDR_JOY1, {7'($urandom), 1'b1});
        if ($urandom_range(1))
          issue(1'b0, $urandom_range(1) ? ADDR_JOY1 : ADDR_JOY2, 8'($urandom));
        if ($urandom_range(99) < 85)
          issue(1'b1, ADDR_JOY1, {7'($urandom), 1'b0});
        repeat ($urandom_range(6, 11))
          issue(1'b0, $urandom_range(1) ? ADDR_JOY1 : ADDR_JOY2, 8'($urandom));
      end else if (kind < 80) begin
        // io window
        issue(1'($urandom), ADDR_IO_BASE + 16'($urandom_range(0, 31)), 8'($urandom));
      end else begin
        // noise over the whole map
        issue(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    req_valid <= 1'b0;

    // drain until nothing is pending, then let the result register empty
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d bus requests over all map windows, both pads and four idling phases",
             sent);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
